// File: hw/rtl/lsp_pkg.sv
// shared types and constants for the lottery scheduler pick block
package lsp_pkg;

    // command codes on i_cmd
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    // fixed field widths
    localparam int RND_W       = 32;
    localparam int DIV_CNT_W   = 5;
    localparam int SLOT_OUT_W  = 5;
    localparam int TOTAL_OUT_W = 21;
    localparam int TICKET_IN_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SCAN,
        ST_SCAN_END,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // word accepted: clear result regs, latch random word
        logic wr_en;       // write one slot
        logic rd_issue;    // read table at walk address, advance address
        logic sum_phase;   // consume read data into the total
        logic div_load;    // start modulo, rewind walk
        logic div_step;    // one restoring step
        logic scan_phase;  // consume read data into the running sum
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic addr_last;
        logic total_zero;
        logic div_last;
    } t_dp_sts;

endpackage

// File: hw/rtl/lsp_ctrl.sv
// control state machine of the lottery scheduler pick block
module lsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_cmd,
    input  lsp_pkg::t_dp_sts i_sts,
    output lsp_pkg::t_dp_cmd o_dp_cmd,
    output logic             busy,
    output logic             o_valid
);

    lsp_pkg::t_state r_state;
    lsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsp_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd == lsp_pkg::CMD_PICK) ? lsp_pkg::ST_SUM
                                                          : lsp_pkg::ST_DONE;
                end
            end
            lsp_pkg::ST_SUM: begin
                if (i_sts.addr_last) begin
                    n_state = lsp_pkg::ST_SUM_END;
                end
            end
            lsp_pkg::ST_SUM_END: begin
                n_state = lsp_pkg::ST_DIV_LOAD;
            end
            lsp_pkg::ST_DIV_LOAD: begin
                n_state = i_sts.total_zero ? lsp_pkg::ST_DONE : lsp_pkg::ST_DIV;
            end
            lsp_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = lsp_pkg::ST_SCAN;
                end
            end
            lsp_pkg::ST_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = lsp_pkg::ST_SCAN_END;
                end
            end
            lsp_pkg::ST_SCAN_END: begin
                n_state = lsp_pkg::ST_DONE;
            end
            lsp_pkg::ST_DONE: begin
                n_state = lsp_pkg::ST_IDLE;
            end
            default: begin
                n_state = lsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_dp_cmd = '0;
        busy     = 1'b1;
        o_valid  = 1'b0;
        unique case (r_state)
            lsp_pkg::ST_IDLE: begin
                busy           = 1'b0;
                o_dp_cmd.load  = start;
                o_dp_cmd.wr_en = start && (i_cmd == lsp_pkg::CMD_WRITE);
            end
            lsp_pkg::ST_SUM: begin
                o_dp_cmd.rd_issue  = 1'b1;
                o_dp_cmd.sum_phase = 1'b1;
            end
            lsp_pkg::ST_SUM_END: begin
                o_dp_cmd.sum_phase = 1'b1;
            end
            lsp_pkg::ST_DIV_LOAD: begin
                o_dp_cmd.div_load = 1'b1;
            end
            lsp_pkg::ST_DIV: begin
                o_dp_cmd.div_step = 1'b1;
            end
            lsp_pkg::ST_SCAN: begin
                o_dp_cmd.rd_issue   = 1'b1;
                o_dp_cmd.scan_phase = 1'b1;
            end
            lsp_pkg::ST_SCAN_END: begin
                o_dp_cmd.scan_phase = 1'b1;
            end
            lsp_pkg::ST_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hw/rtl/lsp_dp.sv
// datapath of the lottery scheduler pick block: slot table, total, modulo, scan
module lsp_dp #(
    parameter int NUM_SLOTS   = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsp_pkg::t_dp_cmd                  i_dp_cmd,
    input  logic [4:0]                        i_slot_index,
    input  logic [lsp_pkg::TICKET_IN_W-1:0]   i_slot_tickets,
    input  logic                              i_slot_eligible,
    input  logic [lsp_pkg::RND_W-1:0]         i_random_word,
    output lsp_pkg::t_dp_sts                  o_sts,
    output logic [lsp_pkg::SLOT_OUT_W-1:0]    o_chosen_slot,
    output logic                              o_found,
    output logic [lsp_pkg::TOTAL_OUT_W-1:0]   o_total_tickets
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int TW = TICKET_BITS + AW;
    localparam int MW = TICKET_BITS + 1;

    // slot table, {eligible, tickets}, with a valid bit per entry
    logic [MW-1:0]          mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_valid;

    logic [AW-1:0]          r_addr;
    logic [MW-1:0]          r_rd_data;
    logic                   r_rd_vld;
    logic                   r_rd_live;
    logic [AW-1:0]          r_rd_idx;

    logic [TW-1:0]          r_total;
    logic [TW-1:0]          r_rem;
    logic [lsp_pkg::RND_W-1:0] r_dvd;
    logic [lsp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [TW-1:0]          r_run;
    logic                   r_hit;
    logic [AW-1:0]          r_chosen;

    logic                   wr_in_range;
    logic [AW-1:0]          wr_addr;
    logic                   rd_elig;
    logic [TW-1:0]          rd_tickets;
    logic [TW:0]            rem_sh;
    logic [TW:0]            rem_diff;
    logic [TW-1:0]          run_next;

    assign wr_in_range = (32'(i_slot_index) < NUM_SLOTS);
    assign wr_addr     = AW'(i_slot_index);

    // an entry never written reads as zero tickets, not eligible
    assign rd_elig    = r_rd_vld && r_rd_data[MW-1];
    assign rd_tickets = rd_elig ? TW'(r_rd_data[TICKET_BITS-1:0]) : '0;

    assign rem_sh   = {r_rem, r_dvd[lsp_pkg::RND_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_total};
    assign run_next = r_run + rd_tickets;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.wr_en && wr_in_range) begin
            mem[wr_addr] <= {i_slot_eligible, TICKET_BITS'(i_slot_tickets)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd_issue) begin
            r_rd_data <= mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (i_dp_cmd.wr_en && wr_in_range) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_live <= i_dp_cmd.rd_issue;
            if (i_dp_cmd.rd_issue) begin
                r_rd_vld <= r_valid[r_addr];
            end
            if (i_dp_cmd.load) begin
                r_hit <= 1'b0;
            end else if (i_dp_cmd.scan_phase && r_rd_live && rd_elig && !r_hit
                         && (run_next > r_rem)) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load || i_dp_cmd.div_load) begin
            r_addr <= '0;
        end else if (i_dp_cmd.rd_issue) begin
            r_addr <= r_addr + AW'(1);
        end

        if (i_dp_cmd.load) begin
            r_total <= '0;
            r_dvd   <= i_random_word;
        end else if (i_dp_cmd.sum_phase && r_rd_live) begin
            r_total <= r_total + rd_tickets;
        end else if (i_dp_cmd.div_step) begin
            r_dvd <= {r_dvd[lsp_pkg::RND_W-2:0], 1'b0};
        end

        // restoring modulo, one quotient bit a cycle
        if (i_dp_cmd.div_load) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_dp_cmd.div_step) begin
            r_rem     <= rem_diff[TW] ? TW'(rem_sh) : TW'(rem_diff);
            r_div_cnt <= r_div_cnt + lsp_pkg::DIV_CNT_W'(1);
        end

        if (i_dp_cmd.div_load) begin
            r_run <= '0;
        end else if (i_dp_cmd.scan_phase && r_rd_live) begin
            r_run <= run_next;
        end

        // winner index, cleared when a word is accepted
        if (i_dp_cmd.load) begin
            r_chosen <= '0;
        end else if (i_dp_cmd.scan_phase && r_rd_live && rd_elig && !r_hit
                     && (run_next > r_rem)) begin
            r_chosen <= r_rd_idx;
        end
    end

    assign o_sts.addr_last  = (r_addr == AW'(NUM_SLOTS - 1));
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.div_last   = (r_div_cnt == lsp_pkg::DIV_CNT_W'(lsp_pkg::RND_W - 1));

    assign o_chosen_slot   = r_hit ? lsp_pkg::SLOT_OUT_W'(r_chosen) : '0;
    assign o_found         = r_hit;
    assign o_total_tickets = lsp_pkg::TOTAL_OUT_W'(r_total);

endmodule

// File: hw/rtl/lottery_scheduler_pick.sv
// top level of the lottery scheduler pick block
// write word: result strobe in the cycle after accept, busy only in that cycle
// pick word: from accept to result, two serial walks over the one-port slot table
// and a 32-step modulo; the modulo and scan walk are skipped with no eligible tickets;
// one word in flight, receiver cannot stall
// synchronous active-low reset clears the slot table valid bits and the controller
module lottery_scheduler_pick #(
    parameter int NUM_SLOTS   = 32,
    parameter int TICKET_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [4:0]                        i_slot_index,
    input  logic [lsp_pkg::TICKET_IN_W-1:0]   i_slot_tickets,
    input  logic                              i_slot_eligible,
    input  logic [lsp_pkg::RND_W-1:0]         i_random_word,
    output logic                              o_valid,
    output logic [lsp_pkg::SLOT_OUT_W-1:0]    o_chosen_slot,
    output logic                              o_found,
    output logic [lsp_pkg::TOTAL_OUT_W-1:0]   o_total_tickets
);

    // command and status between controller and datapath
    lsp_pkg::t_dp_cmd dp_cmd;
    lsp_pkg::t_dp_sts dp_sts;

    // controller: sequences writes, and for picks the sum walk, modulo, scan walk and result strobe
    lsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // datapath: slot table with valid bits, total accumulator,
    // restoring modulo unit and the running-sum scan
    lsp_dp #(
        .NUM_SLOTS   (NUM_SLOTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .i_slot_index    (i_slot_index),
        .i_slot_tickets  (i_slot_tickets),
        .i_slot_eligible (i_slot_eligible),
        .i_random_word   (i_random_word),
        .o_sts           (dp_sts),
        .o_chosen_slot   (o_chosen_slot),
        .o_found         (o_found),
        .o_total_tickets (o_total_tickets)
    );

    // an accepted word always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the result strobe ends the work on a word
    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy stayed high after result strobe");

    // a result is only shown while the word is still in flight
    a_valid_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // no winner means the chosen slot reads zero
    a_no_win_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_chosen_slot == '0))
        else $error("nonzero slot without a winner");

endmodule

// File: tb/tb.sv
// testbench for the lottery scheduler pick block: directed, full-table and random words
`timescale 1ns / 100ps

module tb;

    import lsp_pkg::*;

    localparam int SLOTS = 32;
    localparam int TIX_W = 16;

    // one result word as the block reports it
    typedef struct packed {
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   found;
        logic [TOTAL_OUT_W-1:0] total;
    } t_pick_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_cmd;
    logic [4:0]             i_slot_index;
    logic [TICKET_IN_W-1:0] i_slot_tickets;
    logic                   i_slot_eligible;
    logic [RND_W-1:0]       i_random_word;
    logic                   o_valid;
    logic [SLOT_OUT_W-1:0]  o_chosen_slot;
    logic                   o_found;
    logic [TOTAL_OUT_W-1:0] o_total_tickets;

    // predicted slot table, mirrors what the block holds
    logic [TIX_W-1:0] slot_tix [SLOTS];
    logic             slot_ready [SLOTS];
    logic [4:0]       cur_slot;

    // result words owed by the block, oldest first
    t_pick_result owed_results[$];

    int mismatches;
    bit idle_on;

    lottery_scheduler_pick #(
        .NUM_SLOTS   (SLOTS),
        .TICKET_BITS (TIX_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_slot_index    (i_slot_index),
        .i_slot_tickets  (i_slot_tickets),
        .i_slot_eligible (i_slot_eligible),
        .i_random_word   (i_random_word),
        .o_valid         (o_valid),
        .o_chosen_slot   (o_chosen_slot),
        .o_found         (o_found),
        .o_total_tickets (o_total_tickets)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sum eligible tickets, reduce the random word, walk slots to the winner
    function automatic t_pick_result lottery_draw(logic [31:0] rnd);
        longint unsigned sum;
        longint unsigned win;
        longint unsigned run;
        t_pick_result r;
        r   = '0;
        sum = 0;
        run = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_ready[i]) sum += slot_tix[i];
        end
        r.total = sum[TOTAL_OUT_W-1:0];
        // zero total: nothing found, current slot untouched
        if (sum != 0) begin
            win = rnd % sum;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_ready[i]) begin
                    run += slot_tix[i];
                    if (run > win) begin
                        r.slot   = 5'(i);
                        r.found  = 1'b1;
                        cur_slot = 5'(i);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // update the mirror for an accepted word and queue what it must produce
    function automatic void take_word(logic cmd, logic [4:0] idx, logic [15:0] tix,
                                      logic elig, logic [31:0] rnd);
        if (cmd == CMD_WRITE) begin
            // out-of-range slots are dropped; a write always reports all zeros
            if (int'(idx) < SLOTS) begin
                slot_tix[idx]   = tix[TIX_W-1:0];
                slot_ready[idx] = elig;
            end
            owed_results.push_back('0);
        end else begin
            owed_results.push_back(lottery_draw(rnd));
        end
    endfunction

    // present one word, hold it until accepted; called and returns at a rising edge
    task automatic send_word(logic cmd, logic [4:0] idx, logic [15:0] tix,
                             logic elig, logic [31:0] rnd);
        if (idle_on && $urandom_range(99) < 13) begin
            start <= 1'b0;
            // mostly short gaps, now and then long enough to span a whole pick
            if ($urandom_range(9) == 0) repeat ($urandom_range(110, 5)) @(posedge i_clk);
            else repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_slot_index    <= idx;
        i_slot_tickets  <= tix;
        i_slot_eligible <= elig;
        i_random_word   <= rnd;
        // busy only moves at rising edges, so its mid-cycle value decides the next edge
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        take_word(cmd, idx, tix, elig, rnd);
    endtask

    // hold the sender off until every owed word has come back
    task automatic drain;
        start <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_tix;
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_rnd;
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // empty table, zero-ticket and ineligible slots, ticket boundaries
    task automatic test_edges;
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_WRITE, 5'd0,  16'd0,     1'b1, 32'hFFFF_FFFF);
        send_word(CMD_PICK,  5'd31, 16'hFFFF,  1'b1, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 5'd31, 16'hFFFF,  1'b0, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_WRITE, 5'd31, 16'd1,     1'b1, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 5'd0,  16'hFFFF,  1'b1, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'h0000_0000);
        // winning ticket on either side of the slot 0 / slot 31 boundary
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'd65534);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'd65535);
        send_word(CMD_WRITE, 5'd16, 16'd100,   1'b1, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'hFFFF_FFFF);
        // ineligible slot keeps its tickets but drops out of the draw
        send_word(CMD_WRITE, 5'd0,  16'hFFFF,  1'b0, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'd100);
        send_word(CMD_WRITE, 5'd16, 16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_WRITE, 5'd31, 16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'h0000_0000);
        send_word(CMD_WRITE, 5'd0,  16'hFFFF,  1'b1, 32'h0000_0000);
        send_word(CMD_PICK,  5'd0,  16'd0,     1'b0, 32'd65535);
    endtask

    // every slot at the top ticket count: the largest total the block can report
    task automatic test_full_table;
        for (int s = 0; s < SLOTS; s++) send_word(CMD_WRITE, 5'(s), 16'hFFFF, 1'b1, $urandom);
        send_word(CMD_PICK, 5'd0, 16'd0, 1'b0, 32'h0000_0000);
        send_word(CMD_PICK, 5'd0, 16'd0, 1'b0, 32'hFFFF_FFFF);
        send_word(CMD_PICK, 5'd0, 16'd0, 1'b0, 32'd2097119);
        send_word(CMD_PICK, 5'd0, 16'd0, 1'b0, 32'd2097120);
        repeat (3) send_word(CMD_PICK, 5'($urandom), 16'($urandom), 1'($urandom), $urandom);
        drain;
    endtask

    // mixed writes and picks, with sweeps that retire every slot now and then
    task automatic test_random_mix(int n_words);
        int sent;
        sent = 0;
        while (sent < n_words) begin
            // one long stretch with the sender never idling
            idle_on = !(sent >= 250 && sent < 400);
            if ($urandom_range(49) == 0) begin
                for (int s = 0; s < SLOTS; s++) send_word(CMD_WRITE, 5'(s), rand_tix(), 1'b0, $urandom);
                sent += SLOTS;
            end else if ($urandom_range(99) == 0) begin
                drain;
            end else if ($urandom_range(99) < 55) begin
                send_word(CMD_WRITE, 5'($urandom), rand_tix(), $urandom_range(9) < 7, $urandom);
                sent++;
            end else begin
                send_word(CMD_PICK, 5'($urandom), 16'($urandom), 1'($urandom), rand_rnd());
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    // compare each result word against the oldest owed one, mid-cycle
    always @(negedge i_clk) begin : result_check
        t_pick_result want;
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected word: slot %0d found %0b total %0d",
                         $time, o_chosen_slot, o_found, o_total_tickets);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                if (o_chosen_slot !== want.slot) begin
                    $display("%0t: chosen_slot expected %0d actual %0d",
                             $time, want.slot, o_chosen_slot);
                    mismatches++;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, o_found);
                    mismatches++;
                end
                if (o_total_tickets !== want.total) begin
                    $display("%0t: total_tickets expected %0d actual %0d",
                             $time, want.total, o_total_tickets);
                    mismatches++;
                end
            end
        end
    end

    // run time limit, well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        mismatches = 0;
        idle_on    = 1'b1;
        cur_slot   = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_tix[s]   = '0;
            slot_ready[s] = 1'b0;
        end
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cmd           <= CMD_WRITE;
        i_slot_index    <= '0;
        i_slot_tickets  <= '0;
        i_slot_eligible <= 1'b0;
        i_random_word   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges;
        test_full_table;
        test_random_mix(700);

        // let the last pick finish, then give the block time to go quiet
        drain;
        repeat (120) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_ctrl.sv
hw/rtl/lsp_dp.sv
hw/rtl/lottery_scheduler_pick.sv
tb/tb.sv
